### hw/rtl/packet_length_marker_writer_defines.svh
// Assertion macros for the marker writer checker.
// Depends on nothing; taken in by the checker file only.
`ifndef PACKET_LENGTH_MARKER_WRITER_DEFINES_SVH
`define PACKET_LENGTH_MARKER_WRITER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PLM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PLM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/plm_pkg.sv
// Shared types and constants for the packet length marker writer.
// Used by the front, queue, back and top level modules.
`default_nettype none

package plm_pkg;

    localparam int unsigned MAX_CODE_BYTES = 5;
    localparam int unsigned GRP_W          = 3;
    localparam int unsigned HEADER_BYTES   = 5;
    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    localparam logic [7:0] MARKER_HI = 8'hFF;
    localparam logic [7:0] MARKER_LO = 8'h58;
    localparam logic [7:0] CONT_BIT  = 8'h80;

    localparam logic [1:0] CMD_LEN    = 2'd0;
    localparam logic [1:0] CMD_FINISH = 2'd1;
    localparam logic [1:0] CMD_TILE   = 2'd2;

    localparam logic CFG_SEG_CAP = 1'b0;
    localparam logic CFG_BUF_CAP = 1'b1;

    // One unit of work for the back end: optional length patch, optional
    // segment header, then the code bytes, or a single error byte.
    typedef struct packed {
        logic             err_zero;
        logic             err_ovf;
        logic             patch;
        logic [31:0]      patch_off;
        logic [15:0]      patch_val;
        logic             hdr;
        logic [7:0]       seg_num;
        logic [31:0]      base;
        logic [GRP_W-1:0] groups;
        logic [31:0]      len;
    } t_job;

    typedef struct packed {
        logic valid;
        logic full;
    } t_q_stat;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_ERR,
        PH_PATCH_HI,
        PH_PATCH_LO,
        PH_MARK_HI,
        PH_MARK_LO,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_INDEX,
        PH_CODE
    } t_phase;

endpackage

`default_nettype wire

### hw/rtl/plm_front.sv
// Front end: accepts commands, tracks segment state and builds jobs.
// Depends on plm_pkg.
`default_nettype none

module plm_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_idx,
    input  wire logic [31:0]        i_cfg_data,
    input  wire logic               i_push,
    input  wire logic [1:0]         i_cmd,
    input  wire logic [31:0]        i_packet_len,
    input  wire plm_pkg::t_q_stat   i_q_stat,
    output      logic               o_q_wr,
    output      plm_pkg::t_job      o_q_job
);

    logic [15:0] r_seg_cap;
    logic [31:0] r_buf_cap;
    logic [31:0] r_total;
    logic [15:0] r_seg_bytes;
    logic [31:0] r_lfo;
    logic        r_open;
    logic [7:0]  r_seg_num;

    logic [31:0] n_total;
    logic [15:0] n_seg_bytes;
    logic [31:0] n_lfo;
    logic        n_open;
    logic [7:0]  n_seg_num;

    logic                      accept;
    logic [plm_pkg::GRP_W-1:0] groups;
    logic [15:0]               thr;
    logic                      new_seg;
    logic [3:0]                need;
    logic                      ovf;

    always_comb begin
        if (i_packet_len[31:28] != '0) begin
            groups = plm_pkg::GRP_W'(5);
        end else if (i_packet_len[27:21] != '0) begin
            groups = plm_pkg::GRP_W'(4);
        end else if (i_packet_len[20:14] != '0) begin
            groups = plm_pkg::GRP_W'(3);
        end else if (i_packet_len[13:7] != '0) begin
            groups = plm_pkg::GRP_W'(2);
        end else begin
            groups = plm_pkg::GRP_W'(1);
        end
    end

    assign accept  = i_push && !i_q_stat.full;
    assign thr     = (r_seg_cap > 16'(plm_pkg::HEADER_BYTES))
                   ? r_seg_cap - 16'(plm_pkg::HEADER_BYTES) : 16'd0;
    assign new_seg = !r_open || (r_seg_bytes >= thr);
    assign need    = 4'(groups) + (new_seg ? 4'(plm_pkg::HEADER_BYTES) : 4'd0);
    assign ovf     = ({1'b0, r_total} + 33'(need)) > {1'b0, r_buf_cap};

    always_comb begin
        n_total     = r_total;
        n_seg_bytes = r_seg_bytes;
        n_lfo       = r_lfo;
        n_open      = r_open;
        n_seg_num   = r_seg_num;
        o_q_wr      = 1'b0;

        o_q_job           = '0;
        o_q_job.patch_off = r_lfo;
        o_q_job.patch_val = r_seg_bytes - 16'd2;
        o_q_job.seg_num   = r_seg_num;
        o_q_job.base      = r_total;
        o_q_job.len       = i_packet_len;

        case (i_cmd)
            plm_pkg::CMD_FINISH: begin
                if (r_open) begin
                    o_q_wr        = accept;
                    o_q_job.patch = 1'b1;
                    n_open        = 1'b0;
                    n_seg_bytes   = '0;
                end
            end
            plm_pkg::CMD_TILE: begin
                n_total     = '0;
                n_seg_bytes = '0;
                n_lfo       = '0;
                n_open      = 1'b0;
                n_seg_num   = '0;
            end
            plm_pkg::CMD_LEN: begin
                o_q_wr = accept;
                if (i_packet_len == '0) begin
                    o_q_job.err_zero = 1'b1;
                end else if (ovf) begin
                    o_q_job.err_ovf = 1'b1;
                end else begin
                    o_q_job.patch  = new_seg && r_open;
                    o_q_job.hdr    = new_seg;
                    o_q_job.groups = groups;
                    n_total        = r_total + 32'(need);
                    if (new_seg) begin
                        n_lfo       = r_total + 32'd2;
                        n_seg_num   = r_seg_num + 8'd1;
                        n_seg_bytes = 16'(plm_pkg::HEADER_BYTES) + 16'(groups);
                        n_open      = 1'b1;
                    end else begin
                        n_seg_bytes = r_seg_bytes + 16'(groups);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_cap   <= 16'hFFFF;
            r_buf_cap   <= 32'hFFFF_FFFF;
            r_total     <= '0;
            r_seg_bytes <= '0;
            r_lfo       <= '0;
            r_open      <= 1'b0;
            r_seg_num   <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == plm_pkg::CFG_SEG_CAP) begin
                    r_seg_cap <= i_cfg_data[15:0];
                end else begin
                    r_buf_cap <= i_cfg_data;
                end
            end
            if (accept) begin
                r_total     <= n_total;
                r_seg_bytes <= n_seg_bytes;
                r_lfo       <= n_lfo;
                r_open      <= n_open;
                r_seg_num   <= n_seg_num;
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/plm_queue.sv
// Short job queue between the front and back ends.
// Depends on plm_pkg.
`default_nettype none

module plm_queue #(
    parameter int unsigned DEPTH = plm_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_wr,
    input  wire plm_pkg::t_job     i_job,
    input  wire logic              i_rd,
    output      plm_pkg::t_job     o_job,
    output      plm_pkg::t_q_stat  o_stat
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    plm_pkg::t_job    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_cnt;

    logic do_wr;
    logic do_rd;

    assign o_stat.valid = (r_cnt != '0);
    assign o_stat.full  = (r_cnt == CNT_W'(DEPTH));
    assign o_job        = r_mem[r_rd_ptr];
    assign do_wr        = i_wr && !o_stat.full;
    assign do_rd        = i_rd && o_stat.valid;

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/plm_back.sv
// Back end: expands one job into byte writes into the result register, one per cycle
// while each result is popped. Depends on plm_pkg.
`default_nettype none

module plm_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire plm_pkg::t_job     i_q_job,
    input  wire plm_pkg::t_q_stat  i_q_stat,
    output      logic              o_q_rd,
    input  wire logic              pop,
    output      logic              empty,
    output      logic [31:0]       o_byte_offset,
    output      logic [7:0]        o_byte_value,
    output      logic              o_last_of_run,
    output      logic              o_zero_length_error,
    output      logic              o_overflow_error
);

    plm_pkg::t_phase           r_phase, n_phase;
    plm_pkg::t_job             r_job;
    logic [plm_pkg::GRP_W-1:0] r_grp;
    logic [31:0]               r_off;

    logic        r_out_valid;
    logic [31:0] r_out_off;
    logic [7:0]  r_out_val;
    logic        r_out_last;
    logic        r_out_zerr;
    logic        r_out_oerr;

    logic        step;
    logic        load;
    logic        adv_off;
    logic [31:0] cur_off;
    logic [7:0]  cur_val;
    logic        cur_last;
    logic [7:0]  code_val;
    plm_pkg::t_phase first_phase;

    // Seven-bit group r_grp of the length (the top group holds four bits), most significant first.
    always_comb begin
        case (r_grp)
            3'd5:    code_val = plm_pkg::CONT_BIT | {4'd0, r_job.len[31:28]};
            3'd4:    code_val = plm_pkg::CONT_BIT | {1'b0, r_job.len[27:21]};
            3'd3:    code_val = plm_pkg::CONT_BIT | {1'b0, r_job.len[20:14]};
            3'd2:    code_val = plm_pkg::CONT_BIT | {1'b0, r_job.len[13:7]};
            default: code_val = {1'b0, r_job.len[6:0]};
        endcase
    end

    always_comb begin
        if (i_q_job.err_zero || i_q_job.err_ovf) begin
            first_phase = plm_pkg::PH_ERR;
        end else if (i_q_job.patch) begin
            first_phase = plm_pkg::PH_PATCH_HI;
        end else if (i_q_job.hdr) begin
            first_phase = plm_pkg::PH_MARK_HI;
        end else begin
            first_phase = plm_pkg::PH_CODE;
        end
    end

    assign step = (r_phase != plm_pkg::PH_IDLE) && (!r_out_valid || pop);

    always_comb begin
        cur_off  = r_off;
        cur_val  = '0;
        cur_last = 1'b0;
        adv_off  = 1'b0;
        n_phase  = r_phase;
        case (r_phase)
            plm_pkg::PH_ERR: begin
                cur_off  = r_job.base;
                cur_last = 1'b1;
                n_phase  = plm_pkg::PH_IDLE;
            end
            plm_pkg::PH_PATCH_HI: begin
                cur_off = r_job.patch_off;
                cur_val = r_job.patch_val[15:8];
                n_phase = plm_pkg::PH_PATCH_LO;
            end
            plm_pkg::PH_PATCH_LO: begin
                cur_off  = r_job.patch_off + 32'd1;
                cur_val  = r_job.patch_val[7:0];
                cur_last = !r_job.hdr && (r_job.groups == '0);
                if (r_job.hdr) begin
                    n_phase = plm_pkg::PH_MARK_HI;
                end else if (r_job.groups != '0) begin
                    n_phase = plm_pkg::PH_CODE;
                end else begin
                    n_phase = plm_pkg::PH_IDLE;
                end
            end
            plm_pkg::PH_MARK_HI: begin
                cur_val = plm_pkg::MARKER_HI;
                adv_off = 1'b1;
                n_phase = plm_pkg::PH_MARK_LO;
            end
            plm_pkg::PH_MARK_LO: begin
                cur_val = plm_pkg::MARKER_LO;
                adv_off = 1'b1;
                n_phase = plm_pkg::PH_LEN_HI;
            end
            plm_pkg::PH_LEN_HI: begin
                adv_off = 1'b1;
                n_phase = plm_pkg::PH_LEN_LO;
            end
            plm_pkg::PH_LEN_LO: begin
                adv_off = 1'b1;
                n_phase = plm_pkg::PH_INDEX;
            end
            plm_pkg::PH_INDEX: begin
                cur_val = r_job.seg_num;
                adv_off = 1'b1;
                n_phase = plm_pkg::PH_CODE;
            end
            plm_pkg::PH_CODE: begin
                cur_val  = code_val;
                cur_last = (r_grp == plm_pkg::GRP_W'(1));
                adv_off  = 1'b1;
                n_phase  = cur_last ? plm_pkg::PH_IDLE : plm_pkg::PH_CODE;
            end
            default: begin
                n_phase = plm_pkg::PH_IDLE;
            end
        endcase
    end

    assign load   = ((r_phase == plm_pkg::PH_IDLE) || (step && cur_last)) && i_q_stat.valid;
    assign o_q_rd = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= plm_pkg::PH_IDLE;
        end else if (load) begin
            r_phase <= first_phase;
        end else if (step) begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_job <= i_q_job;
            r_grp <= i_q_job.groups;
            r_off <= i_q_job.base;
        end else if (step) begin
            if (adv_off) begin
                r_off <= r_off + 32'd1;
            end
            if (r_phase == plm_pkg::PH_CODE) begin
                r_grp <= r_grp - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_off  <= cur_off;
            r_out_val  <= cur_val;
            r_out_last <= cur_last;
            r_out_zerr <= (r_phase == plm_pkg::PH_ERR) && r_job.err_zero;
            r_out_oerr <= (r_phase == plm_pkg::PH_ERR) && r_job.err_ovf;
        end
    end

    assign empty               = !r_out_valid;
    assign o_byte_offset       = r_out_off;
    assign o_byte_value        = r_out_val;
    assign o_last_of_run       = r_out_last;
    assign o_zero_length_error = r_out_zerr;
    assign o_overflow_error    = r_out_oerr;

endmodule

`default_nettype wire

### hw/rtl/packet_length_marker_writer.sv
// The first byte of a transaction passes through the job queue, the back-end phase
// register and the result register. Throughput: one result byte per cycle from the
// back-end sequencer while results are popped; a length writes 1 to 12 bytes (patch 2,
// header 5, code 1-5). Commands that write nothing make no job. Synchronous active-low
// reset clears all segment state and the queue; the registers return to their maxima.
`default_nettype none

module packet_length_marker_writer #(
    parameter int unsigned QUEUE_DEPTH = plm_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration: index 0 is the segment capacity, index 1 the buffer capacity.
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    // Input transactions.
    input  wire logic        push,
    output      logic        full,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [31:0] i_packet_len,
    // Result transactions.
    output      logic        empty,
    input  wire logic        pop,
    output      logic [31:0] o_byte_offset,
    output      logic [7:0]  o_byte_value,
    output      logic        o_last_of_run,
    output      logic        o_zero_length_error,
    output      logic        o_overflow_error
);

    // The front end owns all segment bookkeeping and decides, at the moment a
    // transaction is taken, which bytes it will produce. It hands that decision to
    // the back end as a job: an optional patch of the previous segment's length
    // field, an optional new segment header and the length code bytes.
    plm_pkg::t_job    q_in_job;
    plm_pkg::t_job    q_out_job;
    plm_pkg::t_q_stat q_stat;
    logic             q_wr;
    logic             q_rd;

    // Input is refused only while the job queue is full.
    assign full = q_stat.full;

    plm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_push       (push),
        .i_cmd        (i_cmd),
        .i_packet_len (i_packet_len),
        .i_q_stat     (q_stat),
        .o_q_wr       (q_wr),
        .o_q_job      (q_in_job)
    );

    // The queue lets the front keep taking transactions while the back end is
    // still spelling out the bytes of earlier ones.
    plm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_job   (q_in_job),
        .i_rd    (q_rd),
        .o_job   (q_out_job),
        .o_stat  (q_stat)
    );

    // The back end emits one byte per cycle into a result register while results are
    // popped; it picks up the next job as the current job's last byte leaves.
    plm_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_q_job             (q_out_job),
        .i_q_stat            (q_stat),
        .o_q_rd              (q_rd),
        .pop                 (pop),
        .empty               (empty),
        .o_byte_offset       (o_byte_offset),
        .o_byte_value        (o_byte_value),
        .o_last_of_run       (o_last_of_run),
        .o_zero_length_error (o_zero_length_error),
        .o_overflow_error    (o_overflow_error)
    );

endmodule

`default_nettype wire

### hw/rtl/plm_checker.sv
// Port-level checks for the packet length marker writer, bound to the top level.
// Depends on packet_length_marker_writer_defines.svh.
`default_nettype none
`include "packet_length_marker_writer_defines.svh"

module plm_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic [31:0] o_byte_offset,
    input wire logic [7:0]  o_byte_value,
    input wire logic        o_last_of_run,
    input wire logic        o_zero_length_error,
    input wire logic        o_overflow_error
);

    // A waiting result holds until it is taken.
    `PLM_ASSERT_NEXT(a_hold, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_byte_offset) && $stable(o_byte_value) && $stable(o_last_of_run), "result changed while stalled")

    // An error result is a lone zero byte that ends its transaction.
    `PLM_ASSERT_NOW(a_err_last, i_clk, i_rst_n, !empty && (o_zero_length_error || o_overflow_error), o_last_of_run && (o_byte_value == 8'd0), "error result not a lone zero byte")

    // The two error kinds never appear together.
    `PLM_ASSERT_NOW(a_err_excl, i_clk, i_rst_n, !empty, !(o_zero_length_error && o_overflow_error), "both error flags set")

endmodule

bind packet_length_marker_writer plm_checker u_plm_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .empty               (empty),
    .pop                 (pop),
    .o_byte_offset       (o_byte_offset),
    .o_byte_value        (o_byte_value),
    .o_last_of_run       (o_last_of_run),
    .o_zero_length_error (o_zero_length_error),
    .o_overflow_error    (o_overflow_error)
);

`default_nettype wire
